// ===== design/tsp_pkg.sv =====
// package: widths, action codes and payload types for the step pulse generator
`timescale 1ns / 1ps
package tsp_pkg;
	localparam int TICKS_PER_SECOND_DEF = 1000000;
	localparam int COUNT_BITS_DEF = 24;
	localparam int HALF_BITS = 19;
	localparam int SETUP_BITS = 10;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 10;
	localparam int DIV_BITS = 32;

	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_MOVE = 3'd1;
	localparam logic [2:0] ACT_SEGMENT = 3'd2;
	localparam logic [2:0] ACT_LIMIT = 3'd3;
	localparam logic [2:0] ACT_CLEAR = 3'd4;

	localparam logic [CFG_IDX_BITS-1:0] REG_POSITIVE_DIRS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT_IGNORE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIR_SETUP = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] axis;
		logic direction;
		logic [23:0] step_count;
		logic [19:0] step_rate;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic signed [15:0] delta_k;
		logic [15:0] duration_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] step_levels;
		logic [2:0] dir_levels;
		logic [2:0] busy_axes;
		logic limit_hit;
		logic accepted;
	} out_item_t;
endpackage

// ===== design/tsp_if.sv =====
// interfaces: valid/ready channels for input and result items
`timescale 1ns / 1ps
interface tsp_in_if;
	import tsp_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tsp_out_if;
	import tsp_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/three_axis_step_pulse_generator.sv =====
// top level: three-axis step/direction generator with a shared restoring divider
// tick, limit, clear, refused and ignored items: decoded in ST_IDLE, result registered in ST_OUT
// move: one serial division of DIV_BITS quotient bits (no division for a zero rate or count)
// segment: up to a speed and a half period division per axis
// the single restoring divider gives one quotient bit a cycle; a stalled result holds off the next item
// arst_n clears all axis state and flags, and sets the configuration registers to their reset values
`timescale 1ns / 1ps
module three_axis_step_pulse_generator #(
	parameter int TICKS_PER_SECOND = tsp_pkg::TICKS_PER_SECOND_DEF,
	parameter int COUNT_BITS = tsp_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	tsp_in_if.sink in_ch,
	tsp_out_if.source out_ch,
	input logic cfg_we,
	input logic [tsp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [tsp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import tsp_pkg::*;

	localparam logic [DIV_BITS-1:0] TPS = DIV_BITS'(TICKS_PER_SECOND);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
	localparam int DC_BITS = $clog2(DIV_BITS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_DIV = 6'b000100,
		ST_POST = 6'b001000,
		ST_OUT = 6'b010000,
		ST_SEG0 = 6'b100000
	} state_t;

	state_t state_q;
	logic [2:0] pos_dirs_q;
	logic lim_ign_q;
	logic [SETUP_BITS-1:0] setup_cfg_q;

	logic [COUNT_BITS-1:0] steps_q [3];
	logic [HALF_BITS-1:0] half_q [3];
	logic [HALF_BITS-1:0] tick_q [3];
	logic [SETUP_BITS-1:0] wait_q [3];
	logic [2:0] stepl_q, dirl_q;
	logic limit_q;

	in_item_t item_q;
	logic accepted_q;
	logic out_valid_q;
	out_item_t out_q;

	// divider and sequencing
	logic [DIV_BITS-1:0] num_q, den_q, quo_q;
	logic [DIV_BITS:0] rem_q;
	logic [DC_BITS-1:0] dcnt_q;
	logic phase_q; // 0: speed division, 1: half period division
	logic [1:0] ax_q;
	logic seg_q;
	logic [15:0] mag_q;
	logic dsgn_q;

	logic [DIV_BITS:0] rem_sh;
	logic [DIV_BITS:0] rem_sub;
	logic [15:0] dsel;
	logic [DIV_BITS-1:0] half_full;

	assign rem_sh = {rem_q[DIV_BITS-1:0], num_q[DIV_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign half_full = quo_q >> 1;

	always_comb begin
		case (ax_q)
			2'd0: dsel = item_q.delta_x;
			2'd1: dsel = item_q.delta_y;
			default: dsel = item_q.delta_k;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_dirs_q <= '0;
			lim_ign_q <= 1'b0;
			setup_cfg_q <= SETUP_BITS'(5);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POSITIVE_DIRS: pos_dirs_q <= cfg_data[2:0];
				REG_LIMIT_IGNORE: lim_ign_q <= cfg_data[0];
				REG_DIR_SETUP: setup_cfg_q <= cfg_data[SETUP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// main sequencer and axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			limit_q <= 1'b0;
			stepl_q <= '0;
			dirl_q <= '0;
			accepted_q <= 1'b1;
			for (int a = 0; a < 3; a++) begin
				steps_q[a] <= '0;
				half_q[a] <= '0;
				tick_q[a] <= '0;
				wait_q[a] <= '0;
			end
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						item_q <= in_ch.data;
						accepted_q <= 1'b1;
						case (in_ch.data.action)
							ACT_TICK: begin
								for (int a = 0; a < 3; a++) begin
									if (steps_q[a] != '0) begin
										if (wait_q[a] != '0) begin
											wait_q[a] <= wait_q[a] - 1'b1;
										end else if (tick_q[a] + 1'b1 >= half_q[a]) begin
											tick_q[a] <= '0;
											stepl_q[a] <= ~stepl_q[a];
											if (stepl_q[a]) steps_q[a] <= steps_q[a] - 1'b1;
										end else begin
											tick_q[a] <= tick_q[a] + 1'b1;
										end
									end
								end
								state_q <= ST_OUT;
							end
							ACT_MOVE: begin
								if (in_ch.data.axis != 2'd3) begin
									ax_q <= in_ch.data.axis;
									seg_q <= 1'b0;
									mag_q <= '0;
									state_q <= ST_PREP;
								end else state_q <= ST_OUT;
							end
							ACT_SEGMENT: begin
								if (limit_q) begin
									accepted_q <= 1'b0;
									state_q <= ST_OUT;
								end else if (in_ch.data.duration_ms == '0) begin
									for (int a = 0; a < 3; a++) begin
										steps_q[a] <= '0;
										tick_q[a] <= '0;
										wait_q[a] <= '0;
									end
									stepl_q <= '0;
									state_q <= ST_OUT;
								end else begin
									ax_q <= 2'd0;
									seg_q <= 1'b1;
									state_q <= ST_SEG0;
								end
							end
							ACT_LIMIT: begin
								if (!lim_ign_q) begin
									limit_q <= 1'b1;
									for (int a = 0; a < 3; a++) begin
										steps_q[a] <= '0;
										tick_q[a] <= '0;
										wait_q[a] <= '0;
									end
									stepl_q <= '0;
								end
								state_q <= ST_OUT;
							end
							ACT_CLEAR: begin
								limit_q <= 1'b0;
								state_q <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SEG0: begin
					// magnitude and sign of this axis delta, then speed division
					dsgn_q <= dsel[15];
					mag_q <= dsel[15] ? 16'(-dsel) : dsel;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= DC_BITS'(DIV_BITS);
					phase_q <= !seg_q;
					if (seg_q) begin
						num_q <= DIV_BITS'(mag_q) * DIV_BITS'(1000);
						den_q <= DIV_BITS'(item_q.duration_ms);
					end else begin
						num_q <= TPS;
						den_q <= DIV_BITS'(item_q.step_rate);
					end
					if (seg_q ? (mag_q == '0) : (item_q.step_rate == '0
						|| item_q.step_count == '0)) begin
						steps_q[ax_q] <= '0;
						stepl_q[ax_q] <= 1'b0;
						tick_q[ax_q] <= '0;
						wait_q[ax_q] <= '0;
						state_q <= ST_POST;
					end else state_q <= ST_DIV;
				end
				ST_DIV: begin
					// one restoring quotient bit a cycle
					num_q <= num_q << 1;
					if (!rem_sub[DIV_BITS]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DC_BITS'(1)) state_q <= ST_POST;
				end
				ST_POST: begin
					if (!phase_q && (seg_q && mag_q != '0)) begin
						// speed known; zero speed stops, else second division
						if (quo_q == '0) begin
							steps_q[ax_q] <= '0;
							stepl_q[ax_q] <= 1'b0;
							tick_q[ax_q] <= '0;
							wait_q[ax_q] <= '0;
							phase_q <= 1'b1;
							state_q <= ST_POST;
							mag_q <= '0;
						end else begin
							num_q <= TPS;
							den_q <= quo_q;
							rem_q <= '0;
							quo_q <= '0;
							dcnt_q <= DC_BITS'(DIV_BITS);
							phase_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end else begin
						if (seg_q ? (mag_q != '0) : (item_q.step_rate != '0
							&& item_q.step_count != '0)) begin
							if (half_full == '0) half_q[ax_q] <= HALF_BITS'(1);
							else if (half_full > DIV_BITS'({HALF_BITS{1'b1}}))
								half_q[ax_q] <= {HALF_BITS{1'b1}};
							else half_q[ax_q] <= half_full[HALF_BITS-1:0];
							if (seg_q) begin
								steps_q[ax_q] <= COUNT_BITS'(mag_q);
								dirl_q[ax_q] <= pos_dirs_q[ax_q] ^ dsgn_q;
							end else begin
								steps_q[ax_q] <= (item_q.step_count > 24'(CMAX)) ? CMAX
									: COUNT_BITS'(item_q.step_count);
								dirl_q[ax_q] <= item_q.direction;
							end
							wait_q[ax_q] <= setup_cfg_q;
							tick_q[ax_q] <= '0;
							stepl_q[ax_q] <= 1'b0;
						end
						if (seg_q && ax_q != 2'd2) begin
							ax_q <= ax_q + 1'b1;
							state_q <= ST_SEG0;
						end else state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					out_q.step_levels <= stepl_q;
					out_q.dir_levels <= dirl_q;
					for (int a = 0; a < 3; a++) out_q.busy_axes[a] <= steps_q[a] != '0;
					out_q.limit_hit <= limit_q;
					out_q.accepted <= accepted_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== dv/tb_three_axis_step_pulse_generator.sv =====
// testbench: directed and random item streams checked against a behavioral predictor
`timescale 1ns / 1ps
module tb_three_axis_step_pulse_generator;
	import tsp_pkg::*;

	localparam int HALF_MAX = 19'h7FFFF;
	localparam int COUNT_MAX = 24'hFFFFFF;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	tsp_in_if in_ch();
	tsp_out_if out_ch();

	three_axis_step_pulse_generator u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [2:0] pos_dirs;
	logic lim_ignore;
	logic [9:0] setup_ticks;
	logic [23:0] axis_steps [3];
	logic [18:0] axis_half [3];
	logic [18:0] axis_ticks [3];
	logic [9:0] axis_setup [3];
	logic [2:0] step_q;
	logic [2:0] dir_q;
	logic lim_flag;

	out_item_t expected_q[$];
	int errors;
	bit quiet_rx;
	bit quiet_tx;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void stop_axis(input int a);
		axis_steps[a] = '0;
		step_q[a] = 1'b0;
		axis_ticks[a] = '0;
		axis_setup[a] = '0;
	endfunction

	function automatic void load_axis(input int a, input logic dir,
			input longint unsigned steps, input longint unsigned rate);
		longint unsigned half;
		if (rate == 0 || steps == 0) begin
			stop_axis(a);
			return;
		end
		if (steps > COUNT_MAX) steps = COUNT_MAX;
		half = (64'(TICKS_PER_SECOND_DEF) / rate) / 2;
		if (half < 1) half = 1;
		if (half > HALF_MAX) half = HALF_MAX;
		axis_steps[a] = steps[23:0];
		axis_half[a] = half[18:0];
		dir_q[a] = dir;
		axis_setup[a] = setup_ticks;
		axis_ticks[a] = '0;
		step_q[a] = 1'b0;
	endfunction

	function automatic void tick_axis(input int a);
		if (axis_steps[a] == 0) return;
		if (axis_setup[a] != 0) begin
			axis_setup[a]--;
			return;
		end
		axis_ticks[a]++;
		if (axis_ticks[a] >= axis_half[a]) begin
			axis_ticks[a] = '0;
			step_q[a] = ~step_q[a];
			if (!step_q[a]) axis_steps[a]--;
		end
	endfunction

	function automatic void segment_axis(input int a, input logic signed [15:0] d,
			input longint unsigned dur);
		longint unsigned mag;
		mag = (d < 0) ? longint'(-int'(d)) : longint'(d);
		load_axis(a, (d >= 0) ? pos_dirs[a] : ~pos_dirs[a], mag, mag * 1000 / dur);
	endfunction

	// apply one item, return the status it produces
	function automatic out_item_t predict_status(input in_item_t it);
		out_item_t r;
		r.accepted = 1'b1;
		case (it.action)
			ACT_TICK: for (int a = 0; a < 3; a++) tick_axis(a);
			ACT_MOVE: if (it.axis < 3)
				load_axis(it.axis, it.direction, it.step_count, it.step_rate);
			ACT_SEGMENT: begin
				if (lim_flag) r.accepted = 1'b0;
				else if (it.duration_ms == 0) for (int a = 0; a < 3; a++) stop_axis(a);
				else begin
					segment_axis(0, it.delta_x, it.duration_ms);
					segment_axis(1, it.delta_y, it.duration_ms);
					segment_axis(2, it.delta_k, it.duration_ms);
				end
			end
			ACT_LIMIT: if (!lim_ignore) begin
				lim_flag = 1'b1;
				for (int a = 0; a < 3; a++) stop_axis(a);
			end
			ACT_CLEAR: lim_flag = 1'b0;
			default: ;
		endcase
		r.step_levels = step_q;
		r.dir_levels = dir_q;
		for (int a = 0; a < 3; a++) r.busy_axes[a] = (axis_steps[a] != 0);
		r.limit_hit = lim_flag;
		return r;
	endfunction

	function automatic void predictor_reset();
		pos_dirs = '0;
		lim_ignore = 1'b0;
		setup_ticks = 10'd5;
		for (int a = 0; a < 3; a++) begin
			stop_axis(a);
			axis_half[a] = '0;
		end
		dir_q = '0;
		lim_flag = 1'b0;
	endfunction

	// register write, both sides
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POSITIVE_DIRS: pos_dirs = val[2:0];
			REG_LIMIT_IGNORE: lim_ignore = val[0];
			REG_DIR_SETUP: setup_ticks = val[9:0];
			default: ;
		endcase
	endtask

	// drop valid, then wait for every expected status
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// send one transfer; chk_on means a typed-in expectation is compared too
	task automatic send_item(input in_item_t it, input bit chk_on, input out_item_t typed);
		out_item_t p;
		while (!quiet_tx && $urandom_range(99) < 18) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		p = predict_status(it);
		if (chk_on && p !== typed)
			$display("%0t typed status differs: expected %h actual %h", $time, typed, p);
		if (chk_on && p !== typed) errors++;
		expected_q.push_back(p);
		@(negedge clk);
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		it = '0;
		it.axis = 2'($urandom_range(3));
		it.direction = 1'($urandom_range(1));
		r = $urandom_range(99);
		it.step_count = (r < 5) ? 24'($urandom()) : 24'($urandom_range(6));
		r = $urandom_range(99);
		it.step_rate = (r < 10) ? 20'($urandom()) : (r < 20) ? 20'($urandom_range(2))
			: 20'($urandom_range(100000, 1000));
		it.delta_x = (r < 10) ? 16'($urandom())
			: $signed(16'($urandom_range(8))) - 16'sd4;
		it.delta_y = $urandom_range(1) ? 16'($urandom())
			: $signed(16'($urandom_range(8))) - 16'sd4;
		it.delta_k = $urandom_range(1) ? 16'($urandom())
			: $signed(16'($urandom_range(8))) - 16'sd4;
		it.duration_ms = $urandom_range(9) == 0 ? 16'($urandom()) : 16'($urandom_range(2));
		r = $urandom_range(99);
		if (r < 72) it.action = ACT_TICK;
		else if (r < 84) it.action = ACT_MOVE;
		else if (r < 92) it.action = ACT_SEGMENT;
		else if (r < 95) it.action = ACT_LIMIT;
		else if (r < 98) it.action = ACT_CLEAR;
		else it.action = 3'($urandom_range(7, 5));
		return it;
	endfunction

	// result side: random stalls, compare with oldest expectation
	initial begin
		out_item_t exp_r;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= quiet_rx || ($urandom_range(99) >= 18);
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected status transfer: actual %h", $time, out_ch.data);
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (out_ch.data.step_levels !== exp_r.step_levels ||
							out_ch.data.dir_levels !== exp_r.dir_levels ||
							out_ch.data.busy_axes !== exp_r.busy_axes ||
							out_ch.data.limit_hit !== exp_r.limit_hit ||
							out_ch.data.accepted !== exp_r.accepted) begin
						$display("%0t status mismatch: expected %h actual %h",
							$time, exp_r, out_ch.data);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// directed table: item, whether a typed status applies, typed status
	in_item_t dir_items[$];
	bit dir_chk[$];
	out_item_t dir_out[$];

	function automatic void add_row(input logic [2:0] act, input logic [1:0] ax,
			input logic dir, input logic [23:0] cnt, input logic [19:0] rate,
			input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dk,
			input logic [15:0] dur, input bit chk_on, input logic [10:0] typed);
		in_item_t it;
		it = {act, ax, dir, cnt, rate, dx, dy, dk, dur};
		dir_items.push_back(it);
		dir_chk.push_back(chk_on);
		dir_out.push_back(typed);
	endfunction

	initial begin
		errors = 0;
		quiet_rx = 1'b0;
		quiet_tx = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		predictor_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// rows: tick after reset, extremes, every action, special cases
		add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, {9'b0, 1'b0, 1'b1});
		add_row(ACT_MOVE, 0, 1, 24'hFFFFFF, 20'd1000000, 0, 0, 0, 0, 1,
			{3'b000, 3'b001, 3'b001, 1'b0, 1'b1});
		add_row(ACT_MOVE, 1, 1, 24'd3, 20'd1, 0, 0, 0, 0, 0, 0);
		add_row(ACT_MOVE, 2, 1, 24'd2, 20'hFFFFF, 0, 0, 0, 0, 0, 0);
		add_row(ACT_MOVE, 3, 0, 24'd5, 20'd10, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++) add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(ACT_MOVE, 1, 0, 24'd0, 20'd10, 0, 0, 0, 0, 0, 0);
		add_row(ACT_MOVE, 2, 0, 24'd4, 20'd0, 0, 0, 0, 0, 0, 0);
		add_row(ACT_SEGMENT, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h0000, 16'd1, 0, 0);
		add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(ACT_SEGMENT, 0, 0, 0, 0, 16'hFFFF, 16'd1, 16'd5, 16'hFFFF, 0, 0);
		add_row(ACT_SEGMENT, 0, 0, 0, 0, 16'd3, 16'd3, 16'd3, 16'd0, 0, 0);
		add_row(ACT_LIMIT, 0, 0, 0, 0, 0, 0, 0, 0, 1, {3'b000, 3'b110, 3'b000, 1'b1, 1'b1});
		add_row(ACT_SEGMENT, 0, 0, 0, 0, 16'd9, 16'd9, 16'd9, 16'd1, 1,
			{3'b000, 3'b110, 3'b000, 1'b1, 1'b0});
		add_row(ACT_MOVE, 0, 0, 24'd1, 20'd500000, 0, 0, 0, 0, 0, 0);
		add_row(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(3'd5, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		foreach (dir_items[i]) send_item(dir_items[i], dir_chk[i], dir_out[i]);

		// random phases across register settings
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			repeat (250) @(negedge clk);
			write_reg(REG_POSITIVE_DIRS, (ph == 0) ? 10'd7 : 10'($urandom_range(7)));
			write_reg(REG_LIMIT_IGNORE, 10'(ph % 2));
			write_reg(REG_DIR_SETUP, (ph == 1) ? 10'd1023 : (ph == 2) ? 10'd0
				: 10'($urandom_range(6)));
			quiet_tx = (ph == 3);
			quiet_rx = (ph == 3);
			for (int i = 0; i < 250; i++) begin
				send_item(rand_item(), 1'b0, '0);
				if (ph == 2 && i == 100) wait_drained();
			end
		end

		wait_drained();
		repeat (250) @(negedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
design/tsp_pkg.sv
design/tsp_if.sv
design/three_axis_step_pulse_generator.sv
dv/tb_three_axis_step_pulse_generator.sv
